// ----- hdl/selective_repeat_receiver_unit_assert.svh -----
// Assertion macros for the selective repeat receiver.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SRRU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srru assertion failed");
`define SRRU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srru assertion failed");
`else
`define SRRU_ASSERT_IMPL(name, ante, cons)
`define SRRU_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- hdl/srru_pkg.sv -----
// Shared types and codes for the selective repeat receiver.
// No dependencies.
`default_nettype none
package srru_pkg;

  // command codes, front to back
  localparam logic CMD_ACK = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  // result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam int         WIN_W     = 6;
  localparam logic [5:0] WIN_RESET = 6'd8;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic run_done;
    logic busy;
  } back_stat_t;

endpackage
`default_nettype wire

// ----- hdl/srru_cmd_q.sv -----
// Small command queue between the classifier and the delivery engine.
// Depends on srru_pkg.
`default_nettype none
module srru_cmd_q #(
  parameter int W = 17
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire logic [W-1:0]    push_data,
  input  wire logic            pop,
  output logic [W-1:0]         pop_data,
  output srru_pkg::q_stat_t    stat
);
  import srru_pkg::*;

  logic [W-1:0]       mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srru_front.sv -----
// Front end: window register, packet classification, slot write request, command push.
// Depends on srru_pkg.
`default_nettype none
module srru_front #(
  parameter int BUF_DEPTH = 32,
  parameter int SEQ_BITS  = 16,
  parameter int DATA_BITS = 32,
  localparam int IDX_W    = $clog2(BUF_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [5:0]             cfg_window_size,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SEQ_BITS-1:0]    in_seq_number,
  input  wire logic [DATA_BITS-1:0]   in_data_word,
  input  wire logic [SEQ_BITS-1:0]    base,
  input  wire logic [IDX_W-1:0]       base_slot,
  input  wire srru_pkg::q_stat_t      qstat,
  input  wire srru_pkg::back_stat_t   bstat,
  output logic                        push,
  output logic [SEQ_BITS:0]           push_cmd,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_slot,
  output logic [DATA_BITS-1:0]        wr_data
);
  import srru_pkg::*;

  localparam int     CW    = SEQ_BITS + 7;
  localparam int     SUM_W = IDX_W + 1;
  localparam longint HALF  = 64'sd1 << (SEQ_BITS - 1);
  localparam longint CAP   = (HALF < BUF_DEPTH) ? HALF : longint'(BUF_DEPTH);

  logic [WIN_W-1:0]    window_r, window_nxt;
  logic                run_pend_r, run_pend_nxt;
  logic [CW-1:0]       w_eff;
  logic [SEQ_BITS-1:0] ahead, behind;
  logic                is_base, in_win, prev_win, accept;
  logic [SUM_W-1:0]    slot_sum;

  assign cfg_ready  = 1'b1;
  assign window_nxt = (cfg_valid && cfg_ready) ? cfg_window_size : window_r;

  // window saturated into 1 .. min(depth, half the sequence space)
  always_comb begin
    if (window_r == '0) begin
      w_eff = CW'(1);
    end else if (CW'(window_r) > CW'(CAP)) begin
      w_eff = CW'(CAP);
    end else begin
      w_eff = CW'(window_r);
    end
  end

  assign ahead    = in_seq_number - base;
  assign behind   = base - in_seq_number;
  assign is_base  = (ahead == '0);
  assign in_win   = (CW'(ahead) < w_eff);
  assign prev_win = (behind != '0) && (CW'(behind) <= w_eff);

  // seq mod depth: below a wrap, seq = base + ahead; after a wrap, seq < depth
  assign slot_sum = SUM_W'(base_slot) + SUM_W'(ahead);
  always_comb begin
    if (in_seq_number < base) begin
      wr_slot = IDX_W'(in_seq_number);
    end else if (slot_sum >= SUM_W'(BUF_DEPTH)) begin
      wr_slot = IDX_W'(slot_sum - SUM_W'(BUF_DEPTH));
    end else begin
      wr_slot = IDX_W'(slot_sum);
    end
  end

  // base moves only while a run is pending, so hold input until it completes
  assign in_stall = run_pend_r || qstat.full;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && in_win;
  assign wr_data  = in_data_word;
  assign push     = accept && (in_win || prev_win);
  assign push_cmd = {(is_base ? CMD_RUN : CMD_ACK), in_seq_number};

  always_comb begin
    run_pend_nxt = run_pend_r;
    if (push && is_base) begin
      run_pend_nxt = 1'b1;
    end else if (bstat.run_done) begin
      run_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WIN_RESET;
      run_pend_r <= 1'b0;
    end else begin
      window_r   <= window_nxt;
      run_pend_r <= run_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srru_back.sv -----
// Back end: slot store, valid bits, in-order delivery run and result register.
// Depends on srru_pkg.
`default_nettype none
module srru_back #(
  parameter int BUF_DEPTH = 32,
  parameter int SEQ_BITS  = 16,
  parameter int DATA_BITS = 32,
  localparam int IDX_W    = $clog2(BUF_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [IDX_W-1:0]       wr_slot,
  input  wire logic [DATA_BITS-1:0]   wr_data,
  input  wire srru_pkg::q_stat_t      qstat,
  input  wire logic [SEQ_BITS:0]      q_cmd,
  output logic                        q_pop,
  output logic [SEQ_BITS-1:0]         base,
  output logic [IDX_W-1:0]            base_slot,
  output srru_pkg::back_stat_t        bstat,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_kind,
  output logic [SEQ_BITS-1:0]         out_seq_out,
  output logic [DATA_BITS-1:0]        out_data_out,
  output logic                        out_last
);
  import srru_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_r, state_nxt;
  logic [SEQ_BITS-1:0]  base_r, base_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [SEQ_BITS-1:0]  run_seq_r, run_seq_nxt;
  logic [BUF_DEPTH-1:0] valid_r;
  logic [DATA_BITS-1:0] mem_r [BUF_DEPTH];
  logic [DATA_BITS-1:0] rd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [SEQ_BITS-1:0]  out_seq_r, out_seq_nxt;
  logic [DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 ld_ok, deliver, run_done;

  assign base      = base_r;
  assign base_slot = slot_r;
  assign ld_ok     = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    slot_nxt      = slot_r;
    run_seq_nxt   = run_seq_r;
    q_pop         = 1'b0;
    deliver       = 1'b0;
    run_done      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty && ld_ok) begin
          q_pop = 1'b1;
          if (q_cmd[SEQ_BITS] == CMD_RUN) begin
            state_nxt   = ST_RUN;
            run_seq_nxt = q_cmd[SEQ_BITS-1:0];
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ACK;
            out_seq_nxt   = q_cmd[SEQ_BITS-1:0];
            out_data_nxt  = '0;
            out_last_nxt  = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (ld_ok) begin
          out_valid_nxt = 1'b1;
          if (valid_r[slot_r]) begin
            deliver      = 1'b1;
            out_kind_nxt = KIND_DELIVER;
            out_seq_nxt  = base_r;
            out_data_nxt = rd_data_r;
            out_last_nxt = 1'b0;
            base_nxt     = base_r + 1'b1;
            // slot follows seq mod depth, also across the sequence wrap
            if (base_r == '1 || slot_r == IDX_W'(BUF_DEPTH - 1)) begin
              slot_nxt = '0;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
          end else begin
            out_kind_nxt = KIND_ACK;
            out_seq_nxt  = run_seq_r;
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
            run_done     = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign bstat.run_done = run_done;
  assign bstat.busy     = (state_r == ST_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      slot_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_slot] <= 1'b1;
      end
      if (deliver) begin
        valid_r[slot_r] <= 1'b0;
      end
    end
  end

  // slot store; read port prefetches the next base slot, write-first on a hit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_slot] <= wr_data;
    end
    if (wr_en && wr_slot == slot_nxt) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[slot_nxt];
    end
  end

  always_ff @(posedge clk) begin
    run_seq_r  <= run_seq_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_seq_out  = out_seq_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

// ----- hdl/selective_repeat_receiver_unit.sv -----
// Top level of the selective repeat receiver: front classifier, command queue, back end.
// Depends on srru_pkg, srru_front, srru_cmd_q, srru_back and the assertion header.
//
// Receives data packets (sequence number plus one payload word) and returns, per packet
// in the current or previous window, zero or more in-order deliveries and then one ack
// flagged last; other packets are dropped. Ack-only packets are taken one per cycle until
// the four-entry command queue fills; the back end emits at most one result per cycle,
// held while out_stall is high. A packet at the expected base holds the input until the
// delivery run it starts completes, since classifying the next packet needs the base the
// run leaves. Slot valid bits clear at reset; no clearing pass. cfg_ready is always high.
`default_nettype none
`include "selective_repeat_receiver_unit_assert.svh"
module selective_repeat_receiver_unit #(
  parameter int BUF_DEPTH = 32,
  parameter int SEQ_BITS  = 16,
  parameter int DATA_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [5:0]             cfg_window_size,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SEQ_BITS-1:0]    in_seq_number,
  input  wire logic [DATA_BITS-1:0]   in_data_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_kind,
  output logic [SEQ_BITS-1:0]         out_seq_out,
  output logic [DATA_BITS-1:0]        out_data_out,
  output logic                        out_last
);
  import srru_pkg::*;

  localparam int IDX_W = $clog2(BUF_DEPTH);

  q_stat_t              qstat;
  back_stat_t           bstat;
  logic                 push, q_pop, wr_en;
  logic [SEQ_BITS:0]    push_cmd, q_cmd;
  logic [IDX_W-1:0]     wr_slot, base_slot;
  logic [DATA_BITS-1:0] wr_data;
  logic [SEQ_BITS-1:0]  base;

  srru_front #(
    .BUF_DEPTH(BUF_DEPTH), .SEQ_BITS(SEQ_BITS), .DATA_BITS(DATA_BITS)
  ) u_front (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_window_size,
    .in_valid, .in_stall, .in_seq_number, .in_data_word,
    .base, .base_slot, .qstat, .bstat,
    .push, .push_cmd, .wr_en, .wr_slot, .wr_data
  );

  srru_cmd_q #(
    .W(SEQ_BITS + 1)
  ) u_cmd_q (
    .clk, .rst_n,
    .push, .push_data(push_cmd),
    .pop(q_pop), .pop_data(q_cmd),
    .stat(qstat)
  );

  srru_back #(
    .BUF_DEPTH(BUF_DEPTH), .SEQ_BITS(SEQ_BITS), .DATA_BITS(DATA_BITS)
  ) u_back (
    .clk, .rst_n,
    .wr_en, .wr_slot, .wr_data,
    .qstat, .q_cmd, .q_pop,
    .base, .base_slot, .bstat,
    .out_valid, .out_stall, .out_kind, .out_seq_out, .out_data_out, .out_last
  );

  `SRRU_ASSERT_IMPL(a_deliver_not_last, out_valid && out_kind == KIND_DELIVER, !out_last)
  `SRRU_ASSERT_IMPL(a_ack_no_data, out_valid && out_kind == KIND_ACK, out_data_out == '0)
  `SRRU_ASSERT_NEXT(a_run_ends_in_ack, bstat.run_done,
                    out_valid && out_last && out_kind == KIND_ACK)
  `SRRU_ASSERT_IMPL(a_no_input_during_run, bstat.busy, in_stall)

endmodule
`default_nettype wire

// ----- tb/srru_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the selective repeat receiver testbench: window and slot tracking,
// expected delivery/ack queue and result checking. Depends on srru_pkg.
package srru_tb_pkg;
  import srru_pkg::*;

  localparam int SEQ_W  = 16;
  localparam int DATA_W = 32;
  localparam int SLOTS  = 32;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] word;
    logic              last;
  } rx_beat_t;

  class rx_order_checker;
    logic [WIN_W-1:0]  window_reg;
    logic [SEQ_W-1:0]  base;
    bit                slot_full [SLOTS];
    logic [DATA_W-1:0] slot_word [SLOTS];
    rx_beat_t          pending_results [$];
    int                mismatches;
    int                deliveries;
    int                acks;
    int                drops;

    function new();
      window_reg = WIN_RESET;
      base       = '0;
      foreach (slot_full[i]) begin
        slot_full[i] = 1'b0;
        slot_word[i] = '0;
      end
      mismatches = 0;
      deliveries = 0;
      acks       = 0;
      drops      = 0;
    endfunction

    // 0 acts as 1; anything past the buffer depth (or half the seq space) saturates
    function int unsigned eff_window();
      int unsigned w;
      int unsigned cap;
      w   = 32'(window_reg);
      cap = SLOTS;
      if ((1 << (SEQ_W - 1)) < cap) cap = 1 << (SEQ_W - 1);
      if (w < 1) w = 1;
      if (w > cap) w = cap;
      return w;
    endfunction

    function void write_window(logic [WIN_W-1:0] value);
      window_reg = value;
    endfunction

    function void queue_result(logic kind, logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] word,
                               logic last);
      rx_beat_t b;
      b.kind = kind;
      b.seq  = seq;
      b.word = word;
      b.last = last;
      pending_results.push_back(b);
      if (kind == KIND_DELIVER) deliveries++;
      else acks++;
    endfunction

    // Returns the number of result beats the packet causes.
    function int note_packet(logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] word);
      logic [SEQ_W-1:0] ahead;
      logic [SEQ_W-1:0] behind;
      int unsigned      w;
      int unsigned      idx;
      int               run;
      int               before_n;
      before_n = pending_results.size();
      w        = eff_window();
      ahead    = seq - base;
      behind   = base - seq;
      idx      = seq % SLOTS;
      if (ahead == 0) begin
        slot_word[idx] = word;
        slot_full[idx] = 1'b1;
        for (run = 0; run < SLOTS; run++) begin
          idx = base % SLOTS;
          if (!slot_full[idx]) break;
          queue_result(KIND_DELIVER, base, slot_word[idx], 1'b0);
          slot_full[idx] = 1'b0;
          base = base + 1'b1;
        end
        queue_result(KIND_ACK, seq, '0, 1'b1);
      end else if (ahead < w) begin
        slot_word[idx] = word;
        slot_full[idx] = 1'b1;
        queue_result(KIND_ACK, seq, '0, 1'b1);
      end else if (behind >= 1 && behind <= w) begin
        queue_result(KIND_ACK, seq, '0, 1'b1);
      end else begin
        drops++;
      end
      return pending_results.size() - before_n;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic kind, logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] word, logic last);
      rx_beat_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d seq %0h data %0h last %0d",
                                  kind, seq, word, last));
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind got %0d wanted %0d (seq %0h)", kind, want.kind,
                                    want.seq));
        if (seq !== want.seq)
          report_mismatch($sformatf("seq_out got %0h wanted %0h", seq, want.seq));
        if (word !== want.word)
          report_mismatch($sformatf("data_out got %0h wanted %0h (seq %0h)", word, want.word,
                                    want.seq));
        if (last !== want.last)
          report_mismatch($sformatf("last got %0d wanted %0d (seq %0h)", last, want.last,
                                    want.seq));
      end
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

// ----- tb/selective_repeat_receiver_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the selective repeat receiver testbench: clock, reset, packet/config drivers,
// receiver stall, result monitor and watchdog. Depends on srru_pkg, srru_tb_pkg and the DUT.
module selective_repeat_receiver_unit_tb;
  import srru_pkg::*;
  import srru_tb_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_valid       = 1'b0;
  logic              cfg_ready;
  logic [WIN_W-1:0]  cfg_window_size = '0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [SEQ_W-1:0]  in_seq_number   = '0;
  logic [DATA_W-1:0] in_data_word    = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic              out_kind;
  logic [SEQ_W-1:0]  out_seq_out;
  logic [DATA_W-1:0] out_data_out;
  logic              out_last;

  rx_order_checker   sb;
  logic [SEQ_W-1:0]  burst_q [$];
  int                send_idle_pct = 0;
  int                stall_pct     = 0;
  int                hold_requests = 0;
  int                holds_started = 0;
  int                hold_left     = 0;
  int                quiet_cycles  = 0;
  int                packets_in    = 0;
  int                windows_set   = 0;

  logic [SEQ_W-1:0]  dir_seq  [13] = '{16'd0, 16'd3, 16'd3, 16'd2, 16'd1, 16'd11, 16'd12,
                                       16'd0, 16'hfffc, 16'hfffb, 16'hffff, 16'h8004, 16'd4};
  logic [DATA_W-1:0] dir_word [13] = '{32'h0, 32'hffff_ffff, 32'ha5a5_5a5a, 32'h1,
                                       32'h8000_0000, 32'h1234_5678, 32'hdead_beef, 32'h0,
                                       32'hffff_ffff, 32'h5555_aaaa, 32'hffff_ffff,
                                       32'h0f0f_f0f0, 32'hc001_d00d};

  always #4 clk = ~clk;

  selective_repeat_receiver_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_window_size (cfg_window_size),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_seq_number   (in_seq_number),
    .in_data_word    (in_data_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_seq_out     (out_seq_out),
    .out_data_out    (out_data_out),
    .out_last        (out_last)
  );

  // receiver stall; a requested hold keeps stall high until the hold_left counter runs out
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (holds_started != hold_requests) begin
      holds_started = holds_started + 1;
      hold_left     = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_kind, out_seq_out, out_data_out, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles with no beat, %0d results outstanding",
               quiet_cycles, sb.pending());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // in-window packets base+1 .. base+n-1 in random order, then the base packet
  function automatic void build_burst(int unsigned n);
    int          offs [$];
    int unsigned j;
    int          tmp;
    for (int k = 1; k < n; k++) offs.push_back(k);
    for (int i = offs.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = offs[i];
      offs[i] = offs[j];
      offs[j] = tmp;
    end
    foreach (offs[i]) burst_q.push_back(SEQ_W'(sb.base + offs[i]));
    burst_q.push_back(sb.base);
  endfunction

  function automatic logic [SEQ_W-1:0] next_seq();
    int unsigned w;
    int unsigned r;
    w = sb.eff_window();
    r = $urandom_range(0, 99);
    if (burst_q.size() == 0 && r < 22) build_burst($urandom_range(1, w));
    if (burst_q.size() != 0) return burst_q.pop_front();
    if (r < 52) return SEQ_W'(sb.base + $urandom_range(0, w - 1));
    if (r < 67) return SEQ_W'(sb.base - $urandom_range(1, w));
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0:       return SEQ_W'(sb.base + w);
        1:       return SEQ_W'(sb.base + w - 1);
        2:       return SEQ_W'(sb.base - w);
        default: return SEQ_W'(sb.base - w - 1);
      endcase
    end
    return SEQ_W'($urandom);
  endfunction

  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] word,
                             output int produced);
    int gap;
    in_valid      <= 1'b1;
    in_seq_number <= seq;
    in_data_word  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced   = sb.note_packet(seq, word);
    packets_in = packets_in + 1;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // dropped packets leave no result, so give the pipe time to empty after the last beat
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    cfg_valid       <= 1'b1;
    cfg_window_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_window(value);
    windows_set = windows_set + 1;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [WIN_W-1:0] win, input int s_pct, input int r_pct,
                           input int items, input bit pressure, input bit full_run);
    int useful;
    int produced;
    settle();
    write_window(win);
    send_idle_pct = s_pct;
    stall_pct     = r_pct;
    if (pressure) hold_requests = hold_requests + 1;
    if (full_run) build_burst(SLOTS);
    useful = 0;
    // ignored packets do not count toward the phase length
    while (useful < items) begin
      send_packet(next_seq(), $urandom, produced);
      if (produced != 0) useful++;
    end
    burst_q.delete();
  endtask

  initial begin
    int produced;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 8: in-order, duplicate, reorder, window edges, wrap, drops
    foreach (dir_seq[i]) send_packet(dir_seq[i], dir_word[i], produced);

    run_phase(6'd32, 0, 0, 60, 1'b0, 1'b1);
    run_phase(6'd0, 74, 0, 50, 1'b0, 1'b0);
    run_phase(6'd1, 0, 74, 50, 1'b0, 1'b0);
    run_phase(6'd63, 24, 24, 60, 1'b0, 1'b0);
    run_phase(6'd8, 0, 0, 60, 1'b1, 1'b0);
    run_phase(6'd5, 74, 0, 60, 1'b0, 1'b0);
    run_phase(6'd33, 0, 74, 60, 1'b0, 1'b0);
    run_phase(6'($urandom_range(0, 63)), 24, 24, 60, 1'b0, 1'b0);
    settle();

    $display("run covered %0d packets: %0d deliveries, %0d acks, %0d dropped",
             packets_in, sb.deliveries, sb.acks, sb.drops);
    $display("%0d window settings incl. 0, 1, 32 and 63; %0d long receiver hold(s), %0d mismatches",
             windows_set, hold_requests, sb.mismatches);
    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/srru_pkg.sv
hdl/srru_cmd_q.sv
hdl/srru_front.sv
hdl/srru_back.sv
hdl/selective_repeat_receiver_unit.sv
tb/srru_tb_pkg.sv
tb/selective_repeat_receiver_unit_tb.sv
